### sv/ebml_spl_pkg.sv
package ebml_spl_pkg;

    typedef enum logic [1:0] {
        PH_ID      = 2'd0,
        PH_SIZE    = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_ERROR   = 2'd3
    } t_phase;

    localparam int unsigned VAL_W   = 56;
    localparam int unsigned HOLD_N  = 16;
    localparam int unsigned HIDX_W  = $clog2(HOLD_N);
    localparam int unsigned HCNT_W  = HIDX_W + 1;

    localparam logic [VAL_W-1:0] SEGMENT_ID = VAL_W'(32'h0853_8067);
    localparam logic [VAL_W-1:0] CLUSTER_ID = VAL_W'(32'h0F43_B675);
    localparam logic [7:0]       VOID_BYTE  = 8'h80 | 8'h6C;
    localparam logic [7:0]       SIZE_FF    = 8'hFF;

    // number of leading zeros of a vint lead byte (byte known nonzero)
    function automatic logic [2:0] lead_zeros(input logic [7:0] b);
        logic [2:0] n;
        n = 3'd7;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                n = 3'(7 - i);
            end
        end
        return n;
    endfunction

    // all-ones value for some coded vint length
    function automatic logic size_endless(input logic [VAL_W-1:0] s);
        return s == VAL_W'(64'h7F) || s == VAL_W'(64'h3FFF) ||
               s == VAL_W'(64'h1F_FFFF) || s == VAL_W'(64'h0FFF_FFFF) ||
               s == VAL_W'(64'h7_FFFF_FFFF) || s == VAL_W'(64'h3FF_FFFF_FFFF) ||
               s == VAL_W'(64'h1_FFFF_FFFF_FFFF) || s == {VAL_W{1'b1}};
    endfunction

endpackage

### sv/ebml_top_level_element_splitter.sv
// channel   | direction | tdata        | tuser                                   | tlast
// s_axis    | in        | in_byte[7:0] | -                                       | -
// m_axis    | out       | out_byte[7:0]| keep_in_header, element_start, stream_error | last_of_run
//
// one input byte is taken per cycle while no held header is being sent and the output register can take a byte.
// id and size bytes give no request; when the size vint completes, a forwarded held header
// (up to 16 bytes) leaves one byte per free output cycle from the header store; input waits.
// forwarded payload bytes and error reports go out through the output register.
// reset is synchronous, active low; the header store needs no clearing.
// a stalled output holds its request and stops input only when the register is full.
module ebml_top_level_element_splitter
    import ebml_spl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic [2:0] o_m_axis_tuser,   // [0] keep_in_header, [1] element_start, [2] stream_error
    output logic       o_m_axis_tlast    // last_of_run
);

    // parser state
    t_phase             r_phase, n_phase;
    logic [7:0]         r_held [HOLD_N];
    logic [HCNT_W-1:0]  r_held_cnt, n_held_cnt;
    logic [2:0]         r_vleft, n_vleft;
    logic [VAL_W-1:0]   r_id, n_id;
    logic [VAL_W-1:0]   r_size, n_size;
    logic [VAL_W-1:0]   r_pay_left, n_pay_left;
    logic               r_fwd, n_fwd;
    logic               r_to_hdr, n_to_hdr;
    logic               r_clusters, n_clusters;
    logic [HIDX_W-1:0]  r_id_len, n_id_len;

    // header send sequencer
    logic               r_emit_busy, n_emit_busy;
    logic [HCNT_W-1:0]  r_emit_idx, n_emit_idx;
    logic [HCNT_W-1:0]  r_emit_n, n_emit_n;
    logic               r_emit_keep, n_emit_keep;
    logic               r_rewrite, n_rewrite;
    logic [6:0]         r_void_len, n_void_len;

    // output register
    logic               r_m_valid, n_m_valid;
    logic [7:0]         r_m_byte, n_m_byte;
    logic               r_m_keep, n_m_keep;
    logic               r_m_start, n_m_start;
    logic               r_m_last, n_m_last;
    logic               r_m_err, n_m_err;

    logic               w_slot_free;
    logic               w_acc;
    logic               w_wr_en;
    logic [HIDX_W-1:0]  w_wr_addr;
    logic [2:0]         w_len;
    logic [7:0]         w_emit_byte;
    logic [HCNT_W-1:0]  w_pos;
    logic               w_endless;
    logic               w_rw;
    logic [7:0]         w_b;

    assign w_b             = i_s_axis_tdata;
    assign w_slot_free     = !r_m_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_emit_busy && w_slot_free;
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign w_len           = lead_zeros(w_b);

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_byte;
    assign o_m_axis_tuser  = {r_m_err, r_m_start, r_m_keep};
    assign o_m_axis_tlast  = r_m_last;

    // held byte with the segment size rewrite applied on the way out
    always_comb begin
        w_pos       = {1'b0, r_id_len};
        w_emit_byte = r_held[r_emit_idx[HIDX_W-1:0]];
        if (r_rewrite) begin
            if (r_emit_idx == w_pos) begin
                w_emit_byte = SIZE_FF;
            end else if (r_emit_idx == w_pos + HCNT_W'(1)) begin
                w_emit_byte = VOID_BYTE;
            end else if (r_emit_idx == w_pos + HCNT_W'(2)) begin
                w_emit_byte = {1'b1, r_void_len};
            end
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_held_cnt  = r_held_cnt;
        n_vleft     = r_vleft;
        n_id        = r_id;
        n_size      = r_size;
        n_pay_left  = r_pay_left;
        n_fwd       = r_fwd;
        n_to_hdr    = r_to_hdr;
        n_clusters  = r_clusters;
        n_id_len    = r_id_len;
        n_emit_busy = r_emit_busy;
        n_emit_idx  = r_emit_idx;
        n_emit_n    = r_emit_n;
        n_emit_keep = r_emit_keep;
        n_rewrite   = r_rewrite;
        n_void_len  = r_void_len;
        n_m_valid   = r_m_valid && !i_m_axis_tready;
        n_m_byte    = r_m_byte;
        n_m_keep    = r_m_keep;
        n_m_start   = r_m_start;
        n_m_last    = r_m_last;
        n_m_err     = r_m_err;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_held_cnt[HIDX_W-1:0];
        w_endless   = 1'b0;
        w_rw        = 1'b0;

        if (r_emit_busy && w_slot_free) begin
            n_m_valid  = 1'b1;
            n_m_byte   = w_emit_byte;
            n_m_keep   = r_emit_keep;
            n_m_start  = (r_emit_idx == '0);
            n_m_last   = (r_emit_idx == r_emit_n - HCNT_W'(1));
            n_m_err    = 1'b0;
            n_emit_idx = r_emit_idx + HCNT_W'(1);
            if (r_emit_idx == r_emit_n - HCNT_W'(1)) begin
                n_emit_busy = 1'b0;
            end
        end

        if (w_acc) begin
            unique case (r_phase)
                PH_ERROR: begin
                    n_m_valid = 1'b1;
                    n_m_byte  = '0;
                    n_m_keep  = 1'b0;
                    n_m_start = 1'b0;
                    n_m_last  = 1'b1;
                    n_m_err   = 1'b1;
                end
                PH_PAYLOAD: begin
                    if (r_fwd) begin
                        n_m_valid = 1'b1;
                        n_m_byte  = w_b;
                        n_m_keep  = r_to_hdr;
                        n_m_start = 1'b0;
                        n_m_last  = 1'b1;
                        n_m_err   = 1'b0;
                    end
                    n_pay_left = r_pay_left - VAL_W'(1);
                    if (n_pay_left == '0) begin
                        n_phase = PH_ID;
                    end
                end
                PH_ID: begin
                    if (r_held_cnt == '0 && w_b == 8'h00) begin
                        n_phase = PH_ERROR;
                    end else begin
                        w_wr_en    = 1'b1;
                        n_held_cnt = r_held_cnt + HCNT_W'(1);
                        if (r_held_cnt == '0) begin
                            n_id    = VAL_W'(w_b & (8'h7F >> w_len));
                            n_vleft = w_len;
                        end else begin
                            n_id    = {r_id[VAL_W-9:0], w_b};
                            n_vleft = r_vleft - 3'd1;
                        end
                        if (n_vleft == '0) begin
                            n_id_len = n_held_cnt[HIDX_W-1:0];
                            n_phase  = PH_SIZE;
                        end
                    end
                end
                PH_SIZE: begin
                    if (r_held_cnt == {1'b0, r_id_len} && w_b == 8'h00) begin
                        n_phase = PH_ERROR;
                    end else begin
                        w_wr_en    = 1'b1;
                        n_held_cnt = r_held_cnt + HCNT_W'(1);
                        if (r_held_cnt == {1'b0, r_id_len}) begin
                            n_size  = VAL_W'(w_b & (8'h7F >> w_len));
                            n_vleft = w_len;
                        end else begin
                            n_size  = {r_size[VAL_W-9:0], w_b};
                            n_vleft = r_vleft - 3'd1;
                        end
                        if (n_vleft == '0) begin
                            w_endless = size_endless(n_size);
                            n_emit_idx  = '0;
                            n_emit_n    = n_held_cnt;
                            n_void_len  = 7'(n_held_cnt) - 7'(r_id_len) - 7'd3;
                            n_rewrite   = 1'b0;
                            if (r_id == SEGMENT_ID) begin
                                w_rw = w_endless && n_size != VAL_W'(64'h7F) &&
                                       n_size != VAL_W'(64'h3FFF);
                                n_rewrite   = w_rw;
                                n_emit_keep = 1'b1;
                                n_emit_busy = !r_clusters;
                                n_held_cnt  = '0;
                                n_phase     = PH_ID;
                            end else if (w_endless) begin
                                n_phase = PH_ERROR;
                            end else begin
                                if (r_id == CLUSTER_ID) begin
                                    n_clusters = 1'b1;
                                    n_fwd      = 1'b1;
                                    n_to_hdr   = 1'b0;
                                end else begin
                                    n_fwd    = !r_clusters;
                                    n_to_hdr = !r_clusters;
                                end
                                n_emit_keep = n_to_hdr;
                                n_emit_busy = n_fwd;
                                n_pay_left  = n_size;
                                n_held_cnt  = '0;
                                n_phase     = (n_size != '0) ? PH_PAYLOAD : PH_ID;
                            end
                        end
                    end
                end
                default: begin
                    n_phase = PH_ERROR;
                end
            endcase

            // entering the error phase reports at once
            if (n_phase == PH_ERROR && r_phase != PH_ERROR) begin
                n_held_cnt = '0;
                n_vleft    = '0;
                n_m_valid  = 1'b1;
                n_m_byte   = '0;
                n_m_keep   = 1'b0;
                n_m_start  = 1'b0;
                n_m_last   = 1'b1;
                n_m_err    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_held[w_wr_addr] <= w_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_byte   <= n_m_byte;
        r_m_keep   <= n_m_keep;
        r_m_start  <= n_m_start;
        r_m_last   <= n_m_last;
        r_m_err    <= n_m_err;
        r_emit_n   <= n_emit_n;
        r_emit_keep <= n_emit_keep;
        r_void_len <= n_void_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_ID;
            r_held_cnt  <= '0;
            r_vleft     <= '0;
            r_id        <= '0;
            r_size      <= '0;
            r_pay_left  <= '0;
            r_fwd       <= 1'b0;
            r_to_hdr    <= 1'b0;
            r_clusters  <= 1'b0;
            r_id_len    <= '0;
            r_emit_busy <= 1'b0;
            r_emit_idx  <= '0;
            r_rewrite   <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_held_cnt  <= n_held_cnt;
            r_vleft     <= n_vleft;
            r_id        <= n_id;
            r_size      <= n_size;
            r_pay_left  <= n_pay_left;
            r_fwd       <= n_fwd;
            r_to_hdr    <= n_to_hdr;
            r_clusters  <= n_clusters;
            r_id_len    <= n_id_len;
            r_emit_busy <= n_emit_busy;
            r_emit_idx  <= n_emit_idx;
            r_rewrite   <= n_rewrite;
            r_m_valid   <= n_m_valid;
        end
    end

endmodule

### tb/ebml_top_level_element_splitter_tb.sv
module ebml_top_level_element_splitter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ebml_spl_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int TARGET_BYTES = 145;
    localparam int QUIET_BYTES  = 40;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_PRINTS   = 30;

    typedef struct packed {
        logic [7:0] data;
        logic       keep;
        logic       start;
        logic       last;
        logic       err;
    } t_fwd_byte;

    typedef enum int {
        ERR_ID_ZERO,
        ERR_SIZE_ZERO,
        ERR_SHORT_ENDLESS,
        ERR_LONG_ENDLESS
    } t_err_kind;

    logic       i_clk    = 1'b0;
    logic       i_rst_n  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'h00;
    logic       m_tready = 1'b0;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic       m_tlast;

    t_fwd_byte forwarded_q[$];
    int        mismatches = 0;
    int        cycles     = 0;
    int        bytes_sent = 0;
    int        stall_left = 0;
    logic      gaps_on    = 1'b1;

    // parser state mirror, starts at its reset values
    t_phase      ph           = PH_ID;
    logic [7:0]  hold [16];
    int          hold_n       = 0;
    int          id_n         = 0;
    logic [2:0]  vint_left    = 3'd0;
    logic [55:0] id_val       = '0;
    logic [55:0] size_val     = '0;
    logic [55:0] pay_left     = '0;
    logic        pay_fwd      = 1'b0;
    logic        pay_hdr      = 1'b0;
    logic        cluster_seen = 1'b0;

    ebml_top_level_element_splitter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS) $display("%0t mismatch: %s", $time, msg);
    endtask

    function automatic int lead_zero_count(input logic [7:0] b);
        int n;
        n = 0;
        while (n < 8 && !b[7 - n]) n++;
        return n;
    endfunction

    // all ones for some coded length of 1 to 8 bytes
    function automatic logic all_ones_size(input logic [55:0] s);
        logic hit;
        hit = 1'b0;
        for (int k = 1; k <= 8; k++) begin
            if (s == (56'h1 << (7 * k)) - 56'h1) hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic void push_fwd(input logic [7:0] data, input logic keep,
                                     input logic start, input logic last, input logic err);
        t_fwd_byte item;
        item = '{data, keep, start, last, err};
        forwarded_q = {forwarded_q, item};
    endfunction

    function automatic void enter_error();
        ph = PH_ERROR;
        hold_n = 0;
        vint_left = 3'd0;
        push_fwd(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
    endfunction

    function automatic void emit_held(input logic keep);
        for (int k = 0; k < hold_n; k++) begin
            push_fwd(hold[k & 15], keep, k == 0, k == hold_n - 1, 1'b0);
        end
    endfunction

    // advance the parser mirror by one stream byte and queue what it forwards
    task automatic split_byte(input logic [7:0] b);
        int   lz;
        int   p;
        logic fwd;
        logic keep;
        case (ph)
            PH_ERROR: enter_error();
            PH_PAYLOAD: begin
                if (pay_fwd) push_fwd(b, pay_hdr, 1'b0, 1'b1, 1'b0);
                pay_left = pay_left - 56'h1;
                if (pay_left == '0) ph = PH_ID;
            end
            PH_ID: begin
                if (hold_n == 0) begin
                    if (b == 8'h00) begin
                        enter_error();
                        return;
                    end
                    lz = lead_zero_count(b);
                    id_val = 56'(b & (8'h7F >> lz));
                    vint_left = 3'(lz);
                end else begin
                    id_val = {id_val[47:0], b};
                    vint_left = vint_left - 3'd1;
                end
                hold[hold_n & 15] = b;
                hold_n++;
                if (vint_left == 3'd0) begin
                    id_n = hold_n;
                    ph = PH_SIZE;
                end
            end
            PH_SIZE: begin
                if (hold_n == id_n) begin
                    if (b == 8'h00) begin
                        enter_error();
                        return;
                    end
                    lz = lead_zero_count(b);
                    size_val = 56'(b & (8'h7F >> lz));
                    vint_left = 3'(lz);
                end else begin
                    size_val = {size_val[47:0], b};
                    vint_left = vint_left - 3'd1;
                end
                hold[hold_n & 15] = b;
                hold_n++;
                if (vint_left != 3'd0) return;
                if (id_val == SEGMENT_ID) begin
                    // long-coded unknown size: 0xff, then a void element over the rest
                    if (all_ones_size(size_val) && size_val != 56'h7F &&
                        size_val != 56'h3FFF) begin
                        p = id_n;
                        hold[p & 15] = SIZE_FF;
                        hold[(p + 1) & 15] = VOID_BYTE;
                        hold[(p + 2) & 15] = 8'h80 | 8'((hold_n - p - 3) & 127);
                    end
                    if (!cluster_seen) emit_held(1'b1);
                    hold_n = 0;
                    ph = PH_ID;
                end else if (all_ones_size(size_val)) begin
                    enter_error();
                end else begin
                    if (id_val == CLUSTER_ID) begin
                        cluster_seen = 1'b1;
                        fwd = 1'b1;
                        keep = 1'b0;
                    end else begin
                        fwd = !cluster_seen;
                        keep = !cluster_seen;
                    end
                    if (fwd) emit_held(keep);
                    pay_fwd = fwd;
                    pay_hdr = keep;
                    pay_left = size_val;
                    hold_n = 0;
                    ph = (size_val != '0) ? PH_PAYLOAD : PH_ID;
                end
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge i_clk); while (!s_tready);
        split_byte(b);
        bytes_sent++;
    endtask

    // value v coded as an n-byte vint with its length marker
    task automatic send_vint(input logic [55:0] v, input int n);
        logic [63:0] enc;
        enc = (64'h1 << (7 * n)) | (64'(v) & ((64'h1 << (7 * n)) - 64'h1));
        for (int k = n - 1; k >= 0; k--) send_byte(enc[8*k +: 8]);
    endtask

    task automatic send_element(input logic [55:0] id, input int idn,
                                input int sz, input int sn);
        send_vint(id, idn);
        send_vint(56'(sz), sn);
        repeat (sz) send_byte(8'($urandom));
    endtask

    function automatic int pick_size();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    endfunction

    function automatic int pick_size_len();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(2, 8) : 1;
    endfunction

    task automatic send_random_element(input logic allow_cluster);
        int          r;
        int          idn;
        logic [55:0] idv;
        r = $urandom_range(0, 9);
        if (r < 2) begin
            send_vint(SEGMENT_ID, 4);
            if ($urandom_range(0, 1) == 1) begin
                send_vint({56{1'b1}}, $urandom_range(1, 8));
            end else begin
                send_vint(56'(pick_size()), pick_size_len());
            end
        end else if (allow_cluster && r < 5) begin
            send_element(CLUSTER_ID, 4, pick_size(), pick_size_len());
        end else begin
            idn = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
            idv = 56'({$urandom, $urandom}) & ((56'h1 << (7 * idn)) - 56'h1);
            if (idv == SEGMENT_ID || idv == CLUSTER_ID) idv = '0;
            send_element(idv, idn, pick_size(), pick_size_len());
        end
    endtask

    task automatic test_stream_header();
        // header element with payload bytes at both extremes
        send_vint(56'h0A45_DFA3, 4);
        send_vint(56'h2, 1);
        send_byte(8'h00);
        send_byte(8'hFF);
        // segment with an unknown size in eight bytes
        send_vint(SEGMENT_ID, 4);
        send_vint({56{1'b1}}, 8);
        // widest header: eight-byte id, zero size in eight bytes
        send_vint({56{1'b1}}, 8);
        send_vint(56'h0, 8);
    endtask

    task automatic test_random_elements();
        repeat ($urandom_range(3, 6)) send_random_element(1'b0);
        send_element(CLUSTER_ID, 4, pick_size(), pick_size_len());
        while (bytes_sent < TARGET_BYTES) begin
            if (bytes_sent > TARGET_BYTES - QUIET_BYTES) gaps_on = 1'b0;
            send_random_element(1'b1);
        end
    endtask

    // error is sticky until reset, so this runs last
    task automatic test_error_sticky();
        t_err_kind kind;
        gaps_on = 1'b0;
        kind = t_err_kind'($urandom_range(0, 3));
        case (kind)
            ERR_ID_ZERO: send_byte(8'h00);
            ERR_SIZE_ZERO: begin
                send_byte(8'h81);
                send_byte(8'h00);
            end
            ERR_SHORT_ENDLESS: begin
                send_byte(8'h81);
                send_byte(8'hFF);
            end
            default: begin
                send_byte(8'h81);
                send_vint(56'h0FFF_FFFF, 4);
            end
        endcase
        repeat (6) send_byte(8'($urandom));
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 8);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_fwd_byte want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (forwarded_q.size() == 0) begin
                report_mismatch($sformatf("unexpected request, byte %h", m_tdata));
            end else begin
                want = forwarded_q.pop_front();
                if (m_tdata !== want.data)
                    report_mismatch($sformatf("out_byte %h, expected %h", m_tdata, want.data));
                if (m_tuser[0] !== want.keep)
                    report_mismatch($sformatf("keep_in_header %b, expected %b",
                                              m_tuser[0], want.keep));
                if (m_tuser[1] !== want.start)
                    report_mismatch($sformatf("element_start %b, expected %b",
                                              m_tuser[1], want.start));
                if (m_tuser[2] !== want.err)
                    report_mismatch($sformatf("stream_error %b, expected %b",
                                              m_tuser[2], want.err));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last_of_run %b, expected %b",
                                              m_tlast, want.last));
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_stream_header();
        test_random_elements();
        test_error_sticky();
        s_tvalid <= 1'b0;
        while (forwarded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && forwarded_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### ebml_top_level_element_splitter.f
sv/ebml_spl_pkg.sv
sv/ebml_top_level_element_splitter.sv
tb/ebml_top_level_element_splitter_tb.sv
